// ----- hdl/sarp_pkg.sv -----
// ----------------------------------------------------------------------------
// sarp_pkg: shared types for the sector-aligned read planner
// Holds the request and result item layouts and the default plan limit.
// ----------------------------------------------------------------------------
package sarp_pkg;

  // Default limit on the number of requests in one plan.
  localparam int unsigned MaxRequestsDefault = 64;

  // Reset value of the sector shift register.
  localparam logic [4:0] SectorShiftReset = 5'd12;

  // Legal range of the effective sector shift.
  localparam logic [4:0] SectorShiftMin = 5'd9;
  localparam logic [4:0] SectorShiftMax = 5'd16;

  // Widths of the packed stream words.
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 328;

  // One read request as it enters the planner.
  typedef struct packed {
    logic [7:0]  shard_index;
    logic [47:0] file_pos;
    logic [31:0] payload_len;
    logic [39:0] slot_addr;
    logic        last_tensor;
  } req_t;

  // One descriptor as it leaves the planner.
  typedef struct packed {
    logic [7:0]  shard_out;
    logic [47:0] read_start;
    logic [31:0] read_length;
    logic [39:0] staging_place;
    logic [39:0] copy_source;
    logic [39:0] copy_dest;
    logic [31:0] copy_length;
    logic [39:0] total_staging;
    logic [41:0] total_slot;
    logic        plan_done;
    logic        plan_error;
  } res_t;

endpackage

// ----- hdl/sarp_in_stage.sv -----
// ----------------------------------------------------------------------------
// sarp_in_stage: input register of the planner
// Captures one request item and holds it until the planning stage takes it.
// ----------------------------------------------------------------------------
module sarp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sarp_pkg::req_t in_req_i,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output sarp_pkg::req_t req_o
);
  import sarp_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic accept;

  // The register is free when empty or when its item moves on this cycle.
  assign in_ready_o = !valid_q || req_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (req_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ----- hdl/sarp_plan_core.sv -----
// ----------------------------------------------------------------------------
// sarp_plan_core: planning datapath, plan state and result register
// Aligns each read to the sector size, places it in staging, tracks the
// largest slot extent and gives plan totals on a last item without overflow.
// ----------------------------------------------------------------------------
module sarp_plan_core #(
  parameter int unsigned MAX_REQUESTS = sarp_pkg::MaxRequestsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_wdata_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  sarp_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output sarp_pkg::res_t res_o
);
  import sarp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);

  // Configuration and plan state.
  logic [4:0]      shift_q;
  logic [39:0]     staging_q, staging_d;
  logic [40:0]     largest_q, largest_d;
  logic [CntW-1:0] count_q, count_d;
  logic            overflow_q, overflow_d;

  // Result register.
  logic res_valid_q;
  res_t res_q, res_d;

  logic        step;
  logic [4:0]  eff_shift;
  logic [15:0] low_mask;
  logic [15:0] fo_low;
  logic [33:0] span;
  logic [31:0] read_len;
  logic [39:0] staging_next;
  logic [40:0] extent;
  logic [40:0] largest_next;
  logic [41:0] slot_round;
  logic        overflow_now;
  logic        at_limit;

  // The result register is free when empty or drained this cycle.
  assign req_ready_o = !res_valid_q || res_ready_i;
  assign step        = req_valid_i && req_ready_o;

  // Clamp the sector shift to its legal range and form the offset mask.
  always_comb begin
    eff_shift = shift_q;
    if (shift_q < SectorShiftMin) begin
      eff_shift = SectorShiftMin;
    end else if (shift_q > SectorShiftMax) begin
      eff_shift = SectorShiftMax;
    end
  end

  assign low_mask = 16'((17'(1) << eff_shift) - 17'(1));

  // The aligned span only depends on the offset within the first sector,
  // because the aligned start is itself a sector multiple.
  assign fo_low   = req_i.file_pos[15:0] & low_mask;
  assign span     = (34'(fo_low) + 34'(req_i.payload_len) + 34'(low_mask)) & ~34'(low_mask);
  assign read_len = span[31:0];

  // Staging placement and slot extent bookkeeping.
  assign staging_next = staging_q + 40'(read_len);
  assign extent       = 41'(req_i.slot_addr) + 41'(req_i.payload_len);
  assign largest_next = (extent > largest_q) ? extent : largest_q;
  assign slot_round   = (42'(largest_next) + 42'(low_mask)) & ~42'(low_mask);

  // A request that arrives with the count at its limit flags the plan.
  assign at_limit     = (count_q == CntW'(MAX_REQUESTS));
  assign overflow_now = overflow_q || at_limit;

  // Descriptor fields.
  always_comb begin
    res_d.shard_out     = req_i.shard_index;
    res_d.read_start    = req_i.file_pos & ~48'(low_mask);
    res_d.read_length   = read_len;
    res_d.staging_place = staging_q;
    res_d.copy_source   = staging_q + 40'(fo_low);
    res_d.copy_dest     = req_i.slot_addr;
    res_d.copy_length   = req_i.payload_len;
    res_d.total_staging = '0;
    res_d.total_slot    = '0;
    res_d.plan_done     = req_i.last_tensor;
    res_d.plan_error    = overflow_now;
    if (req_i.last_tensor && !overflow_now) begin
      res_d.total_staging = staging_next;
      res_d.total_slot    = slot_round;
    end
  end

  // Next plan state; the last item of a plan clears everything.
  always_comb begin
    staging_d  = staging_q;
    largest_d  = largest_q;
    count_d    = count_q;
    overflow_d = overflow_q;
    if (step) begin
      if (req_i.last_tensor) begin
        staging_d  = '0;
        largest_d  = '0;
        count_d    = '0;
        overflow_d = 1'b0;
      end else begin
        staging_d  = staging_next;
        largest_d  = largest_next;
        overflow_d = overflow_now;
        if (!at_limit) begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= SectorShiftReset;
      staging_q   <= '0;
      largest_q   <= '0;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
      staging_q  <= staging_d;
      largest_q  <= largest_d;
      count_q    <= count_d;
      overflow_q <= overflow_d;
      if (req_ready_o) begin
        res_valid_q <= req_valid_i;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/sector_aligned_read_planner.sv -----
// ----------------------------------------------------------------------------
// sector_aligned_read_planner: direct-I/O read descriptor planner
// Turns sub-tensor read requests into sector-aligned read descriptors with
// staging placement and copy parameters, and reports plan totals.
//
// Channel   Direction  Contents
// s_axis    in         request item: tdata, tlast = last_tensor
// m_axis    out        descriptor item: tdata, tlast = plan_done,
//                      tuser = plan_error
// cfg       in         sector_shift write, taken at any edge with cfg_we_i
//
// One item per cycle sustained while m_axis does not stall; each item goes from
// acceptance through the input register and then the result register to its
// descriptor; the plan state (running staging add) updates on that transfer.
// Reset clears the plan state, both valid flags and sets sector_shift to 12.
// A stall on m_axis holds the result register; s_axis keeps accepting until
// the input register is also occupied.
// ----------------------------------------------------------------------------
module sector_aligned_read_planner #(
  parameter int unsigned MAX_REQUESTS = sarp_pkg::MaxRequestsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [4:0]                     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata from bit 0: shard_index[8], file_pos[48], payload_len[32],
  // slot_addr[40]
  input  logic [sarp_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0: shard_out[8], read_start[48], read_length[32],
  // staging_place[40], copy_source[40], copy_dest[40], copy_length[32],
  // total_staging[40], total_slot[42], zero fill[6]
  output logic [sarp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  // tuser from bit 0: plan_error[1]
  output logic [0:0]                     m_axis_tuser
);
  import sarp_pkg::*;

  req_t in_req;
  req_t req;
  res_t res;
  logic req_valid;
  logic req_ready;

  // Unpack the request item.
  assign in_req.shard_index = s_axis_tdata[7:0];
  assign in_req.file_pos    = s_axis_tdata[55:8];
  assign in_req.payload_len = s_axis_tdata[87:56];
  assign in_req.slot_addr   = s_axis_tdata[127:88];
  assign in_req.last_tensor = s_axis_tlast;

  sarp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  sarp_plan_core #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_plan_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the descriptor item.
  assign m_axis_tdata = {6'b0, res.total_slot, res.total_staging, res.copy_length,
                         res.copy_dest, res.copy_source, res.staging_place,
                         res.read_length, res.read_start, res.shard_out};
  assign m_axis_tlast    = res.plan_done;
  assign m_axis_tuser[0] = res.plan_error;

endmodule

// ----- hdl/sarp_checker.sv -----
// ----------------------------------------------------------------------------
// sarp_checker: port-level checks for the read planner
// Watches the top-level ports and flags descriptors that break the plan
// rules; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module sarp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sarp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic [0:0]                    m_axis_tuser
);
  import sarp_pkg::*;

  // A stalled descriptor stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("descriptor withdrawn while stalled");

  // Totals are only reported on the last descriptor of a plan.
  a_totals_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[321:240] == 82'd0)
    else $error("plan totals on a descriptor that is not last");

  // A plan that overflowed reports zero totals.
  a_totals_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] |-> m_axis_tdata[321:240] == 82'd0)
    else $error("plan totals reported for an overflowed plan");

  // The read start is aligned to at least the smallest sector.
  a_start_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:8] == 9'd0)
    else $error("read start not sector aligned");

  // The fill bits above the last field stay zero.
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[327:322] == 6'd0)
    else $error("descriptor fill bits not zero");

endmodule

bind sector_aligned_read_planner sarp_checker u_sarp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/sector_aligned_read_planner_tb.sv -----
// ----------------------------------------------------------------------------
// sector_aligned_read_planner_tb: self-checking regression for the planner
// Drives read-request items on s_axis and predicts each descriptor with an
// independent plan model held in a scoreboard. Every descriptor on m_axis is
// checked field by field. The run covers directed corner requests, random
// plans under several sector shifts and idle patterns, plans at and over the
// request limit, staging wrap, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module sector_aligned_read_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sarp_pkg::*;

  localparam int unsigned ClkPeriodNs   = 10;
  localparam int unsigned TimeoutNs     = 2_000_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned WrapPlanLen   = 270;

  // Plan model and descriptor checker.
  class read_plan_scoreboard;
    logic [4:0]   shift_cfg;
    logic [39:0]  stage_offset;
    logic [40:0]  slot_high_water;
    int unsigned  plan_len;
    logic         limit_hit;
    res_t         pending_q[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  requests_seen;
    int unsigned  plans_seen;
    int unsigned  plans_over_limit;

    function new();
      shift_cfg        = SectorShiftReset;
      stage_offset     = '0;
      slot_high_water  = '0;
      plan_len         = 0;
      limit_hit        = 1'b0;
      mismatches       = 0;
      results_checked  = 0;
      requests_seen    = 0;
      plans_seen       = 0;
      plans_over_limit = 0;
    endfunction

    // Work out the descriptor for an accepted request and queue it.
    function void note_request(req_t r);
      logic [4:0]  eff;
      logic [63:0] mask;
      logic [63:0] fo;
      logic [63:0] a_start;
      logic [63:0] a_end;
      logic [63:0] span;
      logic [63:0] src;
      logic [63:0] ext;
      logic [63:0] slot_up;
      res_t        d;
      eff = shift_cfg;
      if (eff < SectorShiftMin) begin
        eff = SectorShiftMin;
      end else if (eff > SectorShiftMax) begin
        eff = SectorShiftMax;
      end
      mask = (64'd1 << eff) - 64'd1;
      if (plan_len >= MaxRequestsDefault) begin
        limit_hit = 1'b1;
      end else begin
        plan_len++;
      end
      fo      = 64'(r.file_pos);
      a_start = fo & ~mask;
      a_end   = (fo + 64'(r.payload_len) + mask) & ~mask;
      span    = a_end - a_start;
      src     = 64'(stage_offset) + (fo - a_start);
      d = '0;
      d.shard_out     = r.shard_index;
      d.read_start    = a_start[47:0];
      d.read_length   = span[31:0];
      d.staging_place = stage_offset;
      d.copy_source   = src[39:0];
      d.copy_dest     = r.slot_addr;
      d.copy_length   = r.payload_len;
      d.plan_done     = r.last_tensor;
      // The staging offset advances by the truncated read length and wraps.
      stage_offset = stage_offset + {8'd0, span[31:0]};
      ext = 64'(r.slot_addr) + 64'(r.payload_len);
      if (ext[40:0] > slot_high_water) begin
        slot_high_water = ext[40:0];
      end
      d.plan_error = limit_hit;
      requests_seen++;
      if (r.last_tensor) begin
        plans_seen++;
        if (limit_hit) begin
          plans_over_limit++;
        end else begin
          d.total_staging = stage_offset;
          slot_up         = (64'(slot_high_water) + mask) & ~mask;
          d.total_slot    = slot_up[41:0];
        end
        stage_offset    = '0;
        slot_high_water = '0;
        plan_len        = 0;
        limit_hit       = 1'b0;
      end
      pending_q.push_back(d);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("descriptor %0d: %s expected 0x%0h, got 0x%0h",
                   results_checked, name, want, got);
        end
      end
    endfunction

    // Compare one accepted descriptor with the oldest expected one.
    function void check_descriptor(logic [OutDataW-1:0] data, logic done, logic err);
      res_t want;
      results_checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("descriptor %0d: arrived with none expected, tdata 0x%0h",
                   results_checked, data);
        end
        return;
      end
      want = pending_q.pop_front();
      compare_field("shard_out",     64'(want.shard_out),     64'(data[7:0]));
      compare_field("read_start",    64'(want.read_start),    64'(data[55:8]));
      compare_field("read_length",   64'(want.read_length),   64'(data[87:56]));
      compare_field("staging_place", 64'(want.staging_place), 64'(data[127:88]));
      compare_field("copy_source",   64'(want.copy_source),   64'(data[167:128]));
      compare_field("copy_dest",     64'(want.copy_dest),     64'(data[207:168]));
      compare_field("copy_length",   64'(want.copy_length),   64'(data[239:208]));
      compare_field("total_staging", 64'(want.total_staging), 64'(data[279:240]));
      compare_field("total_slot",    64'(want.total_slot),    64'(data[321:280]));
      compare_field("plan_done",     64'(want.plan_done),     64'(done));
      compare_field("plan_error",    64'(want.plan_error),    64'(err));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [4:0]           cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic [0:0]           m_axis_tuser;

  logic                 rx_hold;
  int unsigned          idle_pct;
  int unsigned          stall_pct;
  read_plan_scoreboard  plan_board = new();

  sector_aligned_read_planner uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriodNs / 2) clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d descriptors still expected.", plan_board.pending_q.size());
    $display("sector_aligned_read_planner regression: fail");
    $finish;
  end

  // Descriptor side: check accepted items and stall at random or on hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      plan_board.check_descriptor(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request and wait until it is accepted.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.slot_addr, r.payload_len, r.file_pos, r.shard_index};
    s_axis_tlast  <= r.last_tensor;
    do @(posedge clk_i); while (!s_axis_tready);
    plan_board.note_request(r);
  endtask

  function automatic req_t req_of(logic [7:0] shard, logic [47:0] fo, logic [31:0] bs,
                                  logic [39:0] so, logic last);
    req_t r;
    r.shard_index = shard;
    r.file_pos    = fo;
    r.payload_len = bs;
    r.slot_addr   = so;
    r.last_tensor = last;
    return r;
  endfunction

  // Random request with a bias toward small sizes and field extremes.
  function automatic req_t make_request(logic last);
    req_t r;
    r.shard_index = 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       r.file_pos = 48'({$urandom, $urandom});
      1:       r.file_pos = 48'($urandom_range(1 << 20));
      2:       r.file_pos = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(65535));
      default: r.file_pos = 48'({$urandom, $urandom}) & ~48'h1FF | 48'($urandom_range(7));
    endcase
    case ($urandom_range(9))
      0:       r.payload_len = $urandom;
      1:       r.payload_len = 32'h8000_0000;
      2:       r.payload_len = 32'hFFFF_FFFF;
      3:       r.payload_len = '0;
      4, 5:    r.payload_len = 32'($urandom_range(1 << 24));
      default: r.payload_len = 32'($urandom_range(4096));
    endcase
    case ($urandom_range(3))
      0:       r.slot_addr = 40'hFF_FFFF_FFFF - 40'($urandom_range(4096));
      1:       r.slot_addr = 40'($urandom_range(1 << 20));
      default: r.slot_addr = 40'({$urandom, $urandom});
    endcase
    r.last_tensor = last;
    return r;
  endfunction

  // One plan of the given length; a wide plan uses reads near 4 GiB each.
  task automatic send_plan(input int unsigned len, input bit wide);
    req_t r;
    for (int unsigned i = 0; i < len; i++) begin
      r = make_request(i == len - 1);
      if (wide) begin
        r.payload_len = 32'hF000_0000 | 32'($urandom_range(32'h0FFF_FFFF));
      end
      send_request(r);
    end
  endtask

  // Random plans until at least the given number of requests went out.
  task automatic run_random_plans(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        len = $urandom_range(MaxRequestsDefault + 4, MaxRequestsDefault - 4);
      end else begin
        len = $urandom_range(16, 1);
      end
      send_plan(len, 1'b0);
      sent += len;
    end
  endtask

  // Stop offering and wait for every expected descriptor.
  task automatic wait_plan_drained();
    s_axis_tvalid <= 1'b0;
    while (plan_board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_sector_shift(input logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    plan_board.shift_cfg = value;
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    idle_pct  = tx_pct;
    stall_pct <= rx_pct;
  endtask

  // Main sequence.
  initial begin
    int unsigned phase_shift[4];
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_shift   = '{9, 16, 0, 31};
    phase_idle    = '{0, 50, 0, 12};
    phase_stall   = '{0, 0, 50, 12};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rx_hold       = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners under the reset sector shift.
    send_request(req_of(8'h00, 48'h0, 32'h0, 40'h0, 1'b0));
    send_request(req_of(8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0));
    send_request(req_of(8'h01, 48'h1001, 32'h1, 40'h10, 1'b0));
    send_request(req_of(8'h02, 48'h2000, 32'h1000, 40'h20, 1'b0));
    send_request(req_of(8'h03, 48'h2FFF, 32'h0, 40'h0, 1'b1));
    send_request(req_of(8'h04, 48'h123, 32'h8000_0000, 40'hFF_FFFF_FFFF, 1'b1));
    send_request(req_of(8'h05, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1));
    send_request(req_of(8'h06, 48'hFFF, 32'h1, 40'h0, 1'b0));
    send_request(req_of(8'h07, 48'h0000_FFFF_F000, 32'h1000, 40'h1000, 1'b0));
    send_request(req_of(8'hAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 40'h55_5555_5555, 1'b0));
    send_request(req_of(8'h55, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 40'hAA_AAAA_AAAA, 1'b1));
    wait_plan_drained();

    // Random plans across sector shifts, including out-of-range settings.
    for (int i = 0; i < 4; i++) begin
      write_sector_shift(5'(phase_shift[i]));
      set_idling(phase_idle[i], phase_stall[i]);
      run_random_plans(100);
      wait_plan_drained();
    end

    // Long receiver hold-off while requests keep coming.
    write_sector_shift(5'($urandom_range(31)));
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    run_random_plans(40);
    wait_plan_drained();

    // Plans at and over the request limit, and one that wraps staging.
    write_sector_shift(5'($urandom_range(31)));
    set_idling(12, 12);
    send_plan(MaxRequestsDefault, 1'b0);
    send_plan(MaxRequestsDefault + 1, 1'b0);
    send_plan(WrapPlanLen, 1'b1);
    wait_plan_drained();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d descriptors from %0d requests in %0d plans (%0d over the limit).",
             plan_board.results_checked, plan_board.requests_seen,
             plan_board.plans_seen, plan_board.plans_over_limit);
    $display("Shifts 12, 9, 16, 0, 31 and random; idle, stall and %0d-cycle hold-off phases.",
             HoldOffCycles);
    if (plan_board.mismatches == 0 && plan_board.pending_q.size() == 0) begin
      $display("sector_aligned_read_planner regression: pass");
    end else begin
      $display("%0d mismatches, %0d descriptors missing.", plan_board.mismatches,
               plan_board.pending_q.size());
      $display("sector_aligned_read_planner regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sarp_pkg.sv
hdl/sarp_in_stage.sv
hdl/sarp_plan_core.sv
hdl/sector_aligned_read_planner.sv
hdl/sarp_checker.sv
dv/sector_aligned_read_planner_tb.sv
